// ===== src/pwt_pkg.sv =====
package pwt_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int KIND_BITS  = 2;
   localparam int FIELD_BITS = 32;
   localparam int WIRE_BITS  = 3;
   localparam int VALUE_BITS = 64;
   localparam int OFFS_BITS  = 32;
   localparam int CODE_BITS  = 3;
   localparam int COUNT_BITS = 4;

   localparam logic [KIND_BITS-1:0] KIND_SCALAR = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_DESC   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_ERROR  = 2'd2;

   localparam logic [WIRE_BITS-1:0] WIRE_VARINT  = 3'd0;
   localparam logic [WIRE_BITS-1:0] WIRE_FIXED64 = 3'd1;
   localparam logic [WIRE_BITS-1:0] WIRE_LENGTH  = 3'd2;
   localparam logic [WIRE_BITS-1:0] WIRE_SGROUP  = 3'd3;
   localparam logic [WIRE_BITS-1:0] WIRE_EGROUP  = 3'd4;
   localparam logic [WIRE_BITS-1:0] WIRE_FIXED32 = 3'd5;

   localparam logic [CODE_BITS-1:0] ERR_NONE      = 3'd0;
   localparam logic [CODE_BITS-1:0] ERR_EARLY_END = 3'd1;
   localparam logic [CODE_BITS-1:0] ERR_LONG      = 3'd2;
   localparam logic [CODE_BITS-1:0] ERR_BAD_LEN   = 3'd3;
   localparam logic [CODE_BITS-1:0] ERR_BAD_WIRE  = 3'd4;
   localparam logic [CODE_BITS-1:0] ERR_DEEP      = 3'd5;

   localparam logic [COUNT_BITS-1:0] VARINT_LAST = 4'd9;
   localparam logic [COUNT_BITS-1:0] FIX64_LAST  = 4'd7;
   localparam logic [COUNT_BITS-1:0] FIX32_LAST  = 4'd3;

endpackage

// ===== src/pwt_req_if.sv =====
interface pwt_req_if;
   import pwt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ===== src/pwt_rsp_if.sv =====
interface pwt_rsp_if;
   import pwt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  kind;
   logic [FIELD_BITS-1:0] field_id;
   logic [WIRE_BITS-1:0]  wire_kind;
   logic [VALUE_BITS-1:0] value;
   logic [OFFS_BITS-1:0]  payload_offset;
   logic [CODE_BITS-1:0]  error_code;

   modport source (output valid, output kind, output field_id, output wire_kind,
                   output value, output payload_offset, output error_code, input ready);
   modport sink (input valid, input kind, input field_id, input wire_kind,
                 input value, input payload_offset, input error_code, output ready);
endinterface

// ===== src/protobuf_wire_tokenizer_top.sv =====
// Protocol-buffer wire-format tokenizer.
// req_ch: one message byte per request, with last set on the final byte.
// rsp_ch: zero or one result per byte: a scalar (varint, fixed32, fixed64),
//   a length-delimited descriptor (offset and length, payload skipped), or an
//   error code. Fields inside groups produce no results.
// Each accepted byte waits in the input register and is decoded into the
//   result register when that is empty or being read. Throughput is one byte
//   per cycle while results are taken, set by the single decode step from the
//   input register through the state registers.
// The input register is taken while a result waits in the output register,
//   so one byte may be absorbed during a stall; further bytes wait on ready.
// After an error, bytes are dropped without results up to the last byte.
// Any last byte returns all decode state, byte position included, to reset.
// Reset (synchronous): both registers empty, decoder awaiting a key at
//   byte position zero with group depth zero.
module protobuf_wire_tokenizer_top #(
   parameter int POSITION_BITS   = 32,
   parameter int MAX_GROUP_DEPTH = 255
) (
   input logic          clock,
   input logic          reset,
   pwt_req_if.sink      req_ch,
   pwt_rsp_if.source    rsp_ch
);
   import pwt_pkg::*;

   localparam int DEPTH_BITS = $clog2(MAX_GROUP_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_KEY,
      PH_VARINT,
      PH_FIXED,
      PH_LENGTH,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [FIELD_BITS-1:0] field_id;
      logic [WIRE_BITS-1:0]  wire_kind;
      logic [VALUE_BITS-1:0] value;
      logic [OFFS_BITS-1:0]  payload_offset;
      logic [CODE_BITS-1:0]  error_code;
   } res_type;

   // input register
   logic                 in_valid_ff;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_last_ff;

   // decode state
   phase_type              phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0]  field_ff, field_in;
   logic [WIRE_BITS-1:0]   wire_ff, wire_in;
   logic [VALUE_BITS-1:0]  remain_ff, remain_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic                   hold_ff, hold_in;

   // result register
   logic    out_valid_ff;
   res_type out_ff;

   logic                     go;
   logic                     res_valid;
   res_type                  res;
   logic [CODE_BITS-1:0]     code;
   logic                     have_key;
   logic [5:0]               v_shamt;
   logic [VALUE_BITS-1:0]    v_acc;
   logic [VALUE_BITS-1:0]    f_acc;
   logic                     v_done;
   logic                     v_long;
   logic [COUNT_BITS-1:0]    cnt_inc;
   logic [VALUE_BITS-1:0]    remain_dec;
   logic [POSITION_BITS-1:0] pos_p1;
   logic [POSITION_BITS-1:0] pay_start;

   assign go           = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || go;

   assign v_shamt    = 6'(7 * cnt_ff);
   assign v_acc      = acc_ff | (VALUE_BITS'(in_byte_ff[6:0]) << v_shamt);
   assign f_acc      = acc_ff | (VALUE_BITS'(in_byte_ff) << {cnt_ff[2:0], 3'b000});
   assign v_done     = !in_byte_ff[7];
   assign v_long     = in_byte_ff[7] && (cnt_ff >= VARINT_LAST);
   assign cnt_inc    = cnt_ff + 4'd1;
   assign remain_dec = remain_ff - 64'd1;
   assign pos_p1     = pos_ff + POSITION_BITS'(1);
   assign pay_start  = pos_p1 - POSITION_BITS'(acc_ff);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      field_in  = field_ff;
      wire_in   = wire_ff;
      remain_in = remain_ff;
      depth_in  = depth_ff;
      hold_in   = hold_ff;
      pos_in    = pos_p1;
      code      = ERR_NONE;
      have_key  = (phase_ff != PH_KEY);
      res_valid = 1'b0;
      res       = '0;

      if (!hold_ff) begin
         case (phase_ff)
            PH_KEY: begin
               if (v_long) begin
                  code = ERR_LONG;
               end else if (v_done) begin
                  field_in  = v_acc[FIELD_BITS+2:3];
                  wire_in   = v_acc[2:0];
                  have_key  = 1'b1;
                  acc_in    = '0;
                  cnt_in    = '0;
                  remain_in = '0;
                  case (v_acc[2:0])
                     WIRE_VARINT:  phase_in = PH_VARINT;
                     WIRE_FIXED64: phase_in = PH_FIXED;
                     WIRE_FIXED32: phase_in = PH_FIXED;
                     WIRE_LENGTH:  phase_in = PH_LENGTH;
                     WIRE_SGROUP: begin
                        if (depth_ff >= DEPTH_BITS'(MAX_GROUP_DEPTH)) begin
                           code = ERR_DEEP;
                        end else begin
                           depth_in = depth_ff + DEPTH_BITS'(1);
                        end
                     end
                     WIRE_EGROUP: begin
                        if (depth_ff != '0) begin
                           depth_in = depth_ff - DEPTH_BITS'(1);
                        end
                     end
                     default: code = ERR_BAD_WIRE;
                  endcase
               end else begin
                  acc_in = v_acc;
                  cnt_in = cnt_inc;
               end
            end
            PH_VARINT: begin
               if (v_long) begin
                  code = ERR_LONG;
               end else if (v_done) begin
                  if (depth_ff == '0) begin
                     res_valid          = 1'b1;
                     res.kind           = KIND_SCALAR;
                     res.field_id       = field_ff;
                     res.wire_kind      = WIRE_VARINT;
                     res.value          = v_acc;
                  end
                  phase_in  = PH_KEY;
                  acc_in    = '0;
                  cnt_in    = '0;
                  remain_in = '0;
               end else begin
                  acc_in = v_acc;
                  cnt_in = cnt_inc;
               end
            end
            PH_FIXED: begin
               acc_in = f_acc;
               cnt_in = cnt_inc;
               if (cnt_ff >= ((wire_ff == WIRE_FIXED64) ? FIX64_LAST : FIX32_LAST)) begin
                  if (depth_ff == '0) begin
                     res_valid          = 1'b1;
                     res.kind           = KIND_SCALAR;
                     res.field_id       = field_ff;
                     res.wire_kind      = wire_ff;
                     res.value          = f_acc;
                  end
                  phase_in  = PH_KEY;
                  acc_in    = '0;
                  cnt_in    = '0;
                  remain_in = '0;
               end
            end
            PH_LENGTH: begin
               if (v_long) begin
                  code = ERR_LONG;
               end else if (v_done) begin
                  if (v_acc == '0) begin
                     if (depth_ff == '0) begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_DESC;
                        res.field_id       = field_ff;
                        res.wire_kind      = WIRE_LENGTH;
                        res.payload_offset = OFFS_BITS'(64'(pos_p1));
                     end
                     phase_in  = PH_KEY;
                     acc_in    = '0;
                     cnt_in    = '0;
                     remain_in = '0;
                  end else begin
                     phase_in  = PH_PAYLOAD;
                     acc_in    = v_acc;
                     cnt_in    = '0;
                     remain_in = v_acc;
                  end
               end else begin
                  acc_in = v_acc;
                  cnt_in = cnt_inc;
               end
            end
            PH_PAYLOAD: begin
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  if (depth_ff == '0) begin
                     res_valid          = 1'b1;
                     res.kind           = KIND_DESC;
                     res.field_id       = field_ff;
                     res.wire_kind      = WIRE_LENGTH;
                     res.value          = acc_ff;
                     res.payload_offset = OFFS_BITS'(64'(pay_start));
                  end
                  phase_in  = PH_KEY;
                  acc_in    = '0;
                  cnt_in    = '0;
                  remain_in = '0;
               end
            end
            default: begin
               phase_in = PH_KEY;
            end
         endcase

         if (code == ERR_NONE && in_last_ff &&
             !(phase_in == PH_KEY && cnt_in == '0 && depth_in == '0)) begin
            code = (phase_in == PH_PAYLOAD) ? ERR_BAD_LEN : ERR_EARLY_END;
         end

         if (code != ERR_NONE) begin
            res_valid          = 1'b1;
            res.kind           = KIND_ERROR;
            res.field_id       = have_key ? field_in : '0;
            res.wire_kind      = have_key ? wire_in : '0;
            res.value          = '0;
            res.payload_offset = OFFS_BITS'(64'(pos_ff));
            res.error_code     = code;
            hold_in            = 1'b1;
         end
      end

      if (in_last_ff) begin
         phase_in  = PH_KEY;
         acc_in    = '0;
         cnt_in    = '0;
         field_in  = '0;
         wire_in   = '0;
         remain_in = '0;
         pos_in    = '0;
         depth_in  = '0;
         hold_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_KEY;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         field_ff     <= '0;
         wire_ff      <= '0;
         remain_ff    <= '0;
         pos_ff       <= '0;
         depth_ff     <= '0;
         hold_ff      <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (go) begin
            in_valid_ff <= 1'b0;
         end
         if (go) begin
            out_valid_ff <= res_valid;
            phase_ff     <= phase_in;
            acc_ff       <= acc_in;
            cnt_ff       <= cnt_in;
            field_ff     <= field_in;
            wire_ff      <= wire_in;
            remain_ff    <= remain_in;
            pos_ff       <= pos_in;
            depth_ff     <= depth_in;
            hold_ff      <= hold_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last;
      end
      if (go && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_ff.kind;
   assign rsp_ch.field_id       = out_ff.field_id;
   assign rsp_ch.wire_kind      = out_ff.wire_kind;
   assign rsp_ch.value          = out_ff.value;
   assign rsp_ch.payload_offset = out_ff.payload_offset;
   assign rsp_ch.error_code     = out_ff.error_code;

   a_hold_silent: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> !res_valid)
      else $error("result produced while dropping bytes after an error");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (go && res_valid && res.kind == KIND_ERROR && !in_last_ff) |=> hold_ff)
      else $error("error did not enter drop mode");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_BITS'(MAX_GROUP_DEPTH))
      else $error("group depth beyond bound");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (go && in_last_ff) |=> (pos_ff == '0 && phase_ff == PH_KEY && !hold_ff))
      else $error("state not cleared after last byte");

endmodule

// ===== sim/tb_protobuf_wire_tokenizer_top.sv =====
module tb_protobuf_wire_tokenizer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pwt_pkg::*;

   localparam int MAX_NEST = 255;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int HOLD_CYCLES = 400;

   localparam logic [WIRE_BITS-1:0] WIRE_RSVD6 = 3'd6;
   localparam logic [WIRE_BITS-1:0] WIRE_RSVD7 = 3'd7;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [FIELD_BITS-1:0] field_id;
      logic [WIRE_BITS-1:0]  wire_kind;
      logic [VALUE_BITS-1:0] value;
      logic [OFFS_BITS-1:0]  payload_offset;
      logic [CODE_BITS-1:0]  error_code;
   } token_type;

   typedef struct {
      logic [BYTE_BITS-1:0] b;
      bit                   lst;
      bit                   typed;
      token_type            tok;
   } dir_row_type;

   typedef enum logic [2:0] {AWAIT_KEY, IN_VARINT, IN_FIXED, IN_LENGTH, IN_PAYLOAD} dec_phase_type;

   localparam token_type NO_TOK = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pwt_req_if req_ch ();
   pwt_rsp_if rsp_ch ();

   protobuf_wire_tokenizer_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // decoder state
   dec_phase_type   dec_phase;
   logic [63:0]     acc;
   int              shift_cnt;
   logic [31:0]     cur_field;
   logic [2:0]      cur_wire;
   logic [63:0]     remaining;
   logic [31:0]     byte_pos;
   int              depth;
   bit              err_hold;

   token_type       token_q[$];
   logic [7:0]      byte_q[$];
   dir_row_type     dir_rows[$];

   int  send_idle_pct = 35;
   int  rcv_idle_pct  = 54;
   bit  start_hold    = 1'b0;
   logic rsp_hold;
   int  fail_count    = 0;
   int  items_sent    = 0;
   int  msgs_sent     = 0;
   int  n_scalar      = 0;
   int  n_desc        = 0;
   int  n_err         = 0;

   function automatic token_type make_tok(input logic [1:0] kind, input logic [31:0] fld,
                                          input logic [2:0] wcode, input logic [63:0] val,
                                          input logic [31:0] off, input logic [2:0] code);
      token_type t;
      t.kind = kind;
      t.field_id = fld;
      t.wire_kind = wcode;
      t.value = val;
      t.payload_offset = off;
      t.error_code = code;
      return t;
   endfunction

   function automatic void back_to_key();
      dec_phase = AWAIT_KEY;
      acc = '0;
      shift_cnt = 0;
      remaining = '0;
   endfunction

   function automatic void reset_decoder();
      back_to_key();
      cur_field = '0;
      cur_wire = '0;
      byte_pos = '0;
      depth = 0;
      err_hold = 1'b0;
   endfunction

   // 0: more bytes, 1: done, 2: too long
   function automatic int take_varint_byte(input logic [7:0] b);
      acc |= 64'(b & 8'h7F) << (7 * shift_cnt);
      if (!b[7]) return 1;
      if (shift_cnt >= 9) return 2;
      shift_cnt++;
      return 0;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input bit lst, output token_type tok);
      logic [31:0] pos;
      logic [2:0]  code;
      bit          have_key;
      bit          got;
      int          r;
      pos = byte_pos;
      code = ERR_NONE;
      have_key = (dec_phase != AWAIT_KEY);
      got = 1'b0;
      tok = NO_TOK;
      if (!err_hold) begin
         case (dec_phase)
            AWAIT_KEY: begin
               r = take_varint_byte(b);
               if (r == 2) begin
                  code = ERR_LONG;
               end else if (r == 1) begin
                  cur_field = acc[34:3];
                  cur_wire = acc[2:0];
                  have_key = 1'b1;
                  back_to_key();
                  case (cur_wire)
                     WIRE_VARINT:                dec_phase = IN_VARINT;
                     WIRE_FIXED64, WIRE_FIXED32: dec_phase = IN_FIXED;
                     WIRE_LENGTH:                dec_phase = IN_LENGTH;
                     WIRE_SGROUP: begin
                        if (depth >= MAX_NEST) code = ERR_DEEP;
                        else depth++;
                     end
                     WIRE_EGROUP: begin
                        if (depth > 0) depth--;
                     end
                     default: code = ERR_BAD_WIRE;
                  endcase
               end
            end
            IN_VARINT: begin
               r = take_varint_byte(b);
               if (r == 2) begin
                  code = ERR_LONG;
               end else if (r == 1) begin
                  if (depth == 0) begin
                     tok = make_tok(KIND_SCALAR, cur_field, WIRE_VARINT, acc, '0, ERR_NONE);
                     got = 1'b1;
                  end
                  back_to_key();
               end
            end
            IN_FIXED: begin
               acc |= 64'(b) << (8 * (shift_cnt % 8));
               shift_cnt++;
               if (shift_cnt >= ((cur_wire == WIRE_FIXED64) ? 8 : 4)) begin
                  if (depth == 0) begin
                     tok = make_tok(KIND_SCALAR, cur_field, cur_wire, acc, '0, ERR_NONE);
                     got = 1'b1;
                  end
                  back_to_key();
               end
            end
            IN_LENGTH: begin
               r = take_varint_byte(b);
               if (r == 2) begin
                  code = ERR_LONG;
               end else if (r == 1) begin
                  if (acc == '0) begin
                     if (depth == 0) begin
                        tok = make_tok(KIND_DESC, cur_field, WIRE_LENGTH, '0, pos + 32'd1,
                                       ERR_NONE);
                        got = 1'b1;
                     end
                     back_to_key();
                  end else begin
                     dec_phase = IN_PAYLOAD;
                     shift_cnt = 0;
                     remaining = acc;
                  end
               end
            end
            default: begin
               remaining--;
               if (remaining == '0) begin
                  if (depth == 0) begin
                     tok = make_tok(KIND_DESC, cur_field, WIRE_LENGTH, acc,
                                    pos + 32'd1 - acc[31:0], ERR_NONE);
                     got = 1'b1;
                  end
                  back_to_key();
               end
            end
         endcase

         if (code == ERR_NONE && lst &&
             !(dec_phase == AWAIT_KEY && shift_cnt == 0 && depth == 0))
            code = (dec_phase == IN_PAYLOAD) ? ERR_BAD_LEN : ERR_EARLY_END;

         if (code != ERR_NONE) begin
            tok = make_tok(KIND_ERROR, have_key ? cur_field : '0, have_key ? cur_wire : '0,
                           '0, pos, code);
            got = 1'b1;
            err_hold = 1'b1;
         end
      end
      if (lst) reset_decoder();
      else byte_pos = pos + 32'd1;
      return got;
   endfunction

   // message builder
   function automatic logic [63:0] pick_field();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return {32'd0, r[31:0]};
         1:       return {3'd0, r[60:0]};
         default: return 64'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic logic [63:0] rand_bits();
      logic [63:0] r;
      int          w;
      r = {$urandom, $urandom};
      w = $urandom_range(1, 64);
      if (w < 64) r &= (64'd1 << w) - 64'd1;
      return r;
   endfunction

   task automatic put_varint(input logic [63:0] v);
      do begin
         byte_q = {byte_q, {(v >> 7) != '0, v[6:0]}};
         v = v >> 7;
      end while (v != '0);
   endtask

   task automatic put_key(input logic [63:0] fnum, input logic [2:0] wcode);
      put_varint({fnum[60:0], wcode});
   endtask

   task automatic gen_field(input int lvl);
      int          sel;
      int          n;
      logic [63:0] f;
      sel = $urandom_range(0, 99);
      if (sel < 26) begin
         put_key(pick_field(), WIRE_VARINT);
         put_varint(rand_bits());
      end else if (sel < 39) begin
         put_key(pick_field(), WIRE_FIXED32);
         repeat (4) byte_q = {byte_q, 8'($urandom_range(0, 255))};
      end else if (sel < 52) begin
         put_key(pick_field(), WIRE_FIXED64);
         repeat (8) byte_q = {byte_q, 8'($urandom_range(0, 255))};
      end else if (sel < 70) begin
         n = $urandom_range(0, 6);
         put_key(pick_field(), WIRE_LENGTH);
         if ($urandom_range(0, 19) == 0) put_varint(rand_bits());
         else put_varint(64'(n));
         repeat (n) byte_q = {byte_q, 8'($urandom_range(0, 255))};
      end else if (sel < 80) begin
         if (lvl < 3) begin
            f = pick_field();
            put_key(f, WIRE_SGROUP);
            repeat ($urandom_range(0, 3)) gen_field(lvl + 1);
            put_key(f, WIRE_EGROUP);
         end else begin
            put_key(pick_field(), WIRE_VARINT);
            put_varint(rand_bits());
         end
      end else if (sel < 84) begin
         put_key(pick_field(), WIRE_EGROUP);
      end else if (sel < 87) begin
         put_key(pick_field(), $urandom_range(0, 1) ? WIRE_RSVD6 : WIRE_RSVD7);
      end else if (sel < 90) begin
         // varint that never ends, as a key or as a value
         if ($urandom_range(0, 1)) put_key(pick_field(), WIRE_VARINT);
         repeat (10) byte_q = {byte_q, 8'h80 | 8'($urandom_range(0, 127))};
      end else if (sel < 95) begin
         // full ten-byte varint, high bits of the tenth byte dropped
         put_key(pick_field(), $urandom_range(0, 1) ? WIRE_VARINT : WIRE_LENGTH);
         repeat (9) byte_q = {byte_q, 8'h80 | 8'($urandom_range(0, 127))};
         byte_q = {byte_q, 8'($urandom_range(0, 127))};
      end else begin
         repeat ($urandom_range(1, 4)) byte_q = {byte_q, 8'($urandom_range(0, 255))};
      end
   endtask

   task automatic build_message();
      byte_q.delete();
      repeat ($urandom_range(1, 5)) gen_field(0);
      if ($urandom_range(0, 7) == 0 && byte_q.size() > 1)
         byte_q = byte_q[0:$urandom_range(0, byte_q.size() - 2)];
   endtask

   task automatic build_nest(input int levels);
      byte_q.delete();
      repeat (levels) put_key(64'd1, WIRE_SGROUP);
      put_key(64'd2, WIRE_VARINT);
      put_varint(64'd5);
      if (levels <= MAX_NEST) begin
         repeat (levels) put_key(64'd1, WIRE_EGROUP);
         put_key(64'd3, WIRE_VARINT);
         put_varint(rand_bits());
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit lst, input bit typed,
                            input token_type typed_tok);
      token_type tok;
      bit        got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last <= lst;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      got = decode_byte(b, lst, tok);
      if (typed) token_q = {token_q, typed_tok};
      else if (got) token_q = {token_q, tok};
      items_sent++;
   endtask

   task automatic send_message();
      for (int i = 0; i < byte_q.size(); i++)
         send_byte(byte_q[i], i == byte_q.size() - 1, 1'b0, NO_TOK);
      msgs_sent++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // result side
   initial begin
      token_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (token_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got kind %0d code %0d",
                        $time, rsp_ch.kind, rsp_ch.error_code);
            end else begin
               want = token_q.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_ch.kind));
               check_field("field id", 64'(want.field_id), 64'(rsp_ch.field_id));
               check_field("wire kind", 64'(want.wire_kind), 64'(rsp_ch.wire_kind));
               check_field("value", want.value, rsp_ch.value);
               check_field("payload_offset", 64'(want.payload_offset),
                           64'(rsp_ch.payload_offset));
               check_field("error_code", 64'(want.error_code), 64'(rsp_ch.error_code));
               case (want.kind)
                  KIND_SCALAR: n_scalar++;
                  KIND_DESC:   n_desc++;
                  default:     n_err++;
               endcase
            end
         end
         if (rsp_hold) rsp_ch.ready <= 1'b0;
         else rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // long receiver stall
   initial begin
      rsp_hold <= 1'b0;
      wait (start_hold);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("[protobuf_wire_tokenizer_top] ERROR");
      $finish;
   end

   initial begin
      int target;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last <= 1'b0;
      reset_decoder();

      dir_rows = '{
         '{8'h08, 1'b0, 1'b0, NO_TOK},
         '{8'h96, 1'b0, 1'b0, NO_TOK},
         '{8'h01, 1'b0, 1'b1, make_tok(KIND_SCALAR, 32'd1, WIRE_VARINT, 64'd150, '0, ERR_NONE)},
         '{8'h12, 1'b0, 1'b0, NO_TOK},
         '{8'h00, 1'b0, 1'b0, NO_TOK},
         '{8'h1A, 1'b0, 1'b0, NO_TOK},
         '{8'h02, 1'b0, 1'b0, NO_TOK},
         '{8'hAB, 1'b0, 1'b0, NO_TOK},
         '{8'hCD, 1'b0, 1'b0, NO_TOK},
         '{8'h0D, 1'b0, 1'b0, NO_TOK},
         '{8'hFF, 1'b0, 1'b0, NO_TOK},
         '{8'hFF, 1'b0, 1'b0, NO_TOK},
         '{8'hFF, 1'b0, 1'b0, NO_TOK},
         '{8'hFF, 1'b0, 1'b1,
           make_tok(KIND_SCALAR, 32'd1, WIRE_FIXED32, 64'hFFFF_FFFF, '0, ERR_NONE)},
         '{8'h1B, 1'b0, 1'b0, NO_TOK},
         '{8'h08, 1'b0, 1'b0, NO_TOK},
         '{8'h00, 1'b0, 1'b0, NO_TOK},
         '{8'h1C, 1'b0, 1'b0, NO_TOK},
         '{8'h24, 1'b0, 1'b0, NO_TOK},
         '{8'h06, 1'b0, 1'b1, make_tok(KIND_ERROR, '0, WIRE_RSVD6, '0, 32'd19, ERR_BAD_WIRE)},
         '{8'h55, 1'b1, 1'b0, NO_TOK},
         '{8'h07, 1'b1, 1'b1, make_tok(KIND_ERROR, '0, WIRE_RSVD7, '0, '0, ERR_BAD_WIRE)},
         '{8'h12, 1'b0, 1'b0, NO_TOK},
         '{8'h05, 1'b0, 1'b0, NO_TOK},
         '{8'h00, 1'b1, 1'b1, make_tok(KIND_ERROR, 32'd2, WIRE_LENGTH, '0, 32'd2, ERR_BAD_LEN)},
         '{8'h09, 1'b0, 1'b0, NO_TOK},
         '{8'h11, 1'b1, 1'b1,
           make_tok(KIND_ERROR, 32'd1, WIRE_FIXED64, '0, 32'd1, ERR_EARLY_END)},
         '{8'hFF, 1'b1, 1'b1, make_tok(KIND_ERROR, '0, '0, '0, '0, ERR_EARLY_END)}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].tok);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 35;
               rcv_idle_pct = 54;
               // fills the limit, then one level too deep
               build_nest(MAX_NEST + 1);
               send_message();
            end
            1: begin
               send_idle_pct = 54;
               rcv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct = 0;
               start_hold = 1'b1;
            end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            build_message();
            send_message();
         end
      end
      req_ch.valid <= 1'b0;

      while (token_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d message bytes in %0d messages, incl. nesting up to and past the limit",
               items_sent, msgs_sent);
      $display("Checked %0d scalars, %0d descriptors and %0d error reports",
               n_scalar, n_desc, n_err);
      if (fail_count == 0) begin
         $display("[protobuf_wire_tokenizer_top] OK");
      end else begin
         $display("[protobuf_wire_tokenizer_top] ERROR");
      end
      $finish;
   end

endmodule
